// ----- hw/rtl/isoparametric_element_mapping_defines.svh -----
// Assertion macros used by the top level of the element mapping RTL.
`ifndef ISOPARAMETRIC_ELEMENT_MAPPING_DEFINES_SVH
`define ISOPARAMETRIC_ELEMENT_MAPPING_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define IEM_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define IEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/iem_pkg.sv -----
// Package with widths, codes and types of the element mapping block.
`default_nettype none

package iem_pkg;

    localparam int WORLD_WIDTH   = 32;
    localparam int REF_FRAC_BITS = 16;

    localparam int REF_W     = REF_FRAC_BITS + 2;
    localparam int FAC_W     = REF_FRAC_BITS + 4;
    localparam int P2_W      = 2 * FAC_W;
    localparam int WGT_W     = 3 * FAC_W;
    localparam int LO_W      = WGT_W / 2;
    localparam int HI_W      = WGT_W - LO_W;
    localparam int ACC_W     = WORLD_WIDTH + WGT_W + 3;
    localparam int SH_HEX    = 3 * REF_FRAC_BITS + 3;
    localparam int SH_PRISM  = 2 * REF_FRAC_BITS + 2;

    localparam int AXES      = 3;
    localparam int VTX_SLOTS = 8;
    localparam int IDX_W     = 3;
    localparam int VTX_W     = AXES * WORLD_WIDTH;

    localparam logic [IDX_W-1:0] LAST_HEX   = IDX_W'(7);
    localparam logic [IDX_W-1:0] LAST_PRISM = IDX_W'(5);

    localparam int IN_BITS  = IDX_W + 3 * WORLD_WIDTH + 3 * REF_W;
    localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = ((VTX_W + 7) / 8) * 8;
    localparam int M_USER_W = 1;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_MAP  = 1'b1
    } action_t;

    typedef enum logic {
        KIND_HEX   = 1'b0,
        KIND_PRISM = 1'b1
    } kind_t;

    typedef struct packed {
        logic valid;
        logic last;
    } step_t;

    typedef struct packed {
        logic  start;
        kind_t kind;
    } map_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/iem_vertex_store.sv -----
// Vertex memory: eight slots of x, y, z, one write and one registered read port.
`default_nettype none

module iem_vertex_store import iem_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [VTX_W-1:0] wr_data,   // x, y, z from bit 0 up
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [VTX_W-1:0] rd_data
);

    logic [VTX_W-1:0] mem [VTX_SLOTS];
    logic [VTX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/iem_weight_gen.sv -----
// Shape-function weight pipeline: factors, pair product, triple product.
`default_nettype none

module iem_weight_gen import iem_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic signed [REF_W-1:0] ref_r,
    input  wire logic signed [REF_W-1:0] ref_s,
    input  wire logic signed [REF_W-1:0] ref_t,
    input  wire kind_t                   kind,
    input  wire logic [IDX_W-1:0]        idx,
    input  wire step_t                   step_in,
    output logic signed [WGT_W-1:0]      weight,
    output step_t                        step_out
);

    localparam logic signed [FAC_W-1:0] FAC_ONE = FAC_W'(1) <<< REF_FRAC_BITS;
    localparam logic signed [FAC_W-1:0] FAC_UNIT = FAC_W'(1);

    logic signed [FAC_W-1:0] r_ext, s_ext, t_ext;
    logic signed [FAC_W-1:0] fa, fb, fc;
    logic signed [P2_W-1:0]  p2_next, p2_reg;
    logic signed [FAC_W-1:0] fc_reg;
    logic signed [WGT_W-1:0] w_next, w_reg;
    step_t                   step_a_reg, step_b_reg;

    assign r_ext = FAC_W'(ref_r);
    assign s_ext = FAC_W'(ref_s);
    assign t_ext = FAC_W'(ref_t);

    always_comb begin
        fa = FAC_ONE - r_ext;
        fb = FAC_ONE - s_ext;
        fc = FAC_ONE - t_ext;
        if (kind == KIND_HEX) begin
            if (idx[0] ^ idx[1]) begin
                fa = FAC_ONE + r_ext;
            end
            if (idx[1]) begin
                fb = FAC_ONE + s_ext;
            end
            if (idx[2]) begin
                fc = FAC_ONE + t_ext;
            end
        end else begin
            fc = FAC_UNIT;
            case (idx)
                3'd0: begin
                    fa = -(r_ext + t_ext);
                    fb = FAC_ONE - s_ext;
                end
                3'd1: begin
                    fa = FAC_ONE + r_ext;
                    fb = FAC_ONE - s_ext;
                end
                3'd2: begin
                    fa = FAC_ONE + r_ext;
                    fb = FAC_ONE + s_ext;
                end
                3'd3: begin
                    fa = -(r_ext + t_ext);
                    fb = FAC_ONE + s_ext;
                end
                3'd4: begin
                    fa = FAC_ONE - s_ext;
                    fb = FAC_ONE + t_ext;
                end
                default: begin
                    fa = FAC_ONE + s_ext;
                    fb = FAC_ONE + t_ext;
                end
            endcase
        end
    end

    assign p2_next = fa * fb;
    assign w_next  = p2_reg * fc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_a_reg <= '0;
            step_b_reg <= '0;
        end else begin
            step_a_reg <= step_in;
            step_b_reg <= step_a_reg;
        end
        p2_reg <= p2_next;
        fc_reg <= fc;
        w_reg  <= w_next;
    end

    assign weight   = w_reg;
    assign step_out = step_b_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/iem_mac.sv -----
// Three-lane multiply-accumulate with rounding offset and saturation.
`default_nettype none

module iem_mac import iem_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire map_ctl_t                map_ctl,
    input  wire kind_t                   kind,
    input  wire logic [VTX_W-1:0]        vertex,
    input  wire logic signed [WGT_W-1:0] weight,
    input  wire step_t                   step_in,
    output logic                         acc_done,
    output logic [VTX_W-1:0]             world,
    output logic                         saturated
);

    localparam int LO_P_W = WORLD_WIDTH + LO_W + 1;
    localparam int HI_P_W = WORLD_WIDTH + HI_W;
    localparam int TOP_W  = ACC_W - WORLD_WIDTH + 1;

    localparam logic signed [ACC_W-1:0] HALF_HEX   = ACC_W'(1) <<< (SH_HEX - 1);
    localparam logic signed [ACC_W-1:0] HALF_PRISM = ACC_W'(1) <<< (SH_PRISM - 1);
    localparam logic [WORLD_WIDTH-1:0]  W_MAX = {1'b0, {(WORLD_WIDTH-1){1'b1}}};
    localparam logic [WORLD_WIDTH-1:0]  W_MIN = {1'b1, {(WORLD_WIDTH-1){1'b0}}};

    logic [VTX_W-1:0] vtx_reg;
    step_t            step_p_reg, step_t_reg;
    logic [AXES-1:0]  ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_p_reg <= '0;
            step_t_reg <= '0;
        end else begin
            step_p_reg <= step_in;
            step_t_reg <= step_p_reg;
        end
        vtx_reg <= vertex;
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        logic signed [WORLD_WIDTH-1:0] vtx;
        logic signed [LO_P_W-1:0]      lo_next, lo_reg;
        logic signed [HI_P_W-1:0]      hi_next, hi_reg;
        logic signed [ACC_W-1:0]       term_next, term_reg;
        logic signed [ACC_W-1:0]       acc_reg, acc_next;
        logic signed [ACC_W-1:0]       shifted;
        logic [TOP_W-1:0]              top_bits;

        assign vtx       = $signed(vtx_reg[g*WORLD_WIDTH +: WORLD_WIDTH]);
        assign lo_next   = vtx * $signed({1'b0, weight[LO_W-1:0]});
        assign hi_next   = vtx * $signed(weight[WGT_W-1:LO_W]);
        assign term_next = (ACC_W'(hi_reg) <<< LO_W) + ACC_W'(lo_reg);

        always_comb begin
            acc_next = acc_reg;
            if (map_ctl.start) begin
                acc_next = (map_ctl.kind == KIND_HEX) ? HALF_HEX : HALF_PRISM;
            end else if (step_t_reg.valid) begin
                acc_next = acc_reg + term_reg;
            end
        end

        always_ff @(posedge aclk) begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            term_reg <= term_next;
            acc_reg  <= acc_next;
        end

        assign shifted  = (kind == KIND_HEX) ? (acc_reg >>> SH_HEX) : (acc_reg >>> SH_PRISM);
        assign top_bits = shifted[ACC_W-1:WORLD_WIDTH-1];
        assign ovf[g]   = (top_bits != {TOP_W{shifted[ACC_W-1]}});

        assign world[g*WORLD_WIDTH +: WORLD_WIDTH] =
            !ovf[g] ? shifted[WORLD_WIDTH-1:0] : (shifted[ACC_W-1] ? W_MIN : W_MAX);
    end

    assign saturated = |ovf;
    assign acc_done  = step_t_reg.valid && step_t_reg.last;

endmodule

`default_nettype wire

// ----- hw/rtl/isoparametric_element_mapping.sv -----
// Top level of the isoparametric element mapping block.
`default_nettype none

// Maps reference coordinates (r,s,t) of a hexahedron or prism to world
// coordinates. A load transfer (tuser action 0) writes one vertex slot and
// gives no result. A map transfer (action 1) reads the vertex memory one slot
// per cycle, eight slots for a hexahedron and six for a prism, feeding a
// weight pipeline and three parallel multiply-accumulate lanes; the block
// takes no new item from its transfer until the result is moved to the output
// register. A finished result sits in the output register while the next item
// is taken. Every slot read by a map must have been loaded since reset.
module isoparametric_element_mapping import iem_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // vertex_index, vert_x, vert_y, vert_z, ref_r, ref_s, ref_t, zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // action, element_kind
    input  wire logic [S_USER_W-1:0] s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // world_x, world_y, world_z
    output logic      [M_DATA_W-1:0] m_tdata,
    // saturated
    output logic      [M_USER_W-1:0] m_tuser
);

    `include "isoparametric_element_mapping_defines.svh"

    localparam int X_LSB = IDX_W;
    localparam int R_LSB = X_LSB + VTX_W;
    localparam int S_LSB = R_LSB + REF_W;
    localparam int T_LSB = S_LSB + REF_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        idx_reg, last_idx;
    kind_t                   kind_reg;
    logic signed [REF_W-1:0] r_reg, s_reg, t_reg;
    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg;
    logic [M_USER_W-1:0]     m_user_reg;

    action_t          in_action;
    kind_t            in_kind;
    logic             accept;
    map_ctl_t         map_ctl;
    step_t            issue_step, wgt_step;
    logic [VTX_W-1:0] rd_data, world;
    logic signed [WGT_W-1:0] weight;
    logic             acc_done, sat;

    assign in_action = action_t'(s_tuser[0]);
    assign in_kind   = kind_t'(s_tuser[1]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign last_idx  = (kind_reg == KIND_HEX) ? LAST_HEX : LAST_PRISM;

    assign map_ctl.start    = accept && (in_action == ACT_MAP);
    assign map_ctl.kind     = in_kind;
    assign issue_step.valid = (state_reg == ST_RUN);
    assign issue_step.last  = (idx_reg == last_idx);

    iem_vertex_store u_store (
        .aclk    (aclk),
        .wr_en   (accept && (in_action == ACT_LOAD)),
        .wr_addr (s_tdata[IDX_W-1:0]),
        .wr_data (s_tdata[X_LSB +: VTX_W]),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    iem_weight_gen u_weight (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ref_r    (r_reg),
        .ref_s    (s_reg),
        .ref_t    (t_reg),
        .kind     (kind_reg),
        .idx      (idx_reg),
        .step_in  (issue_step),
        .weight   (weight),
        .step_out (wgt_step)
    );

    iem_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .map_ctl   (map_ctl),
        .kind      (kind_reg),
        .vertex    (rd_data),
        .weight    (weight),
        .step_in   (wgt_step),
        .acc_done  (acc_done),
        .world     (world),
        .saturated (sat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (map_ctl.start) begin
                        state_reg <= ST_RUN;
                        idx_reg   <= '0;
                        kind_reg  <= in_kind;
                        r_reg     <= $signed(s_tdata[R_LSB +: REF_W]);
                        s_reg     <= $signed(s_tdata[S_LSB +: REF_W]);
                        t_reg     <= $signed(s_tdata[T_LSB +: REF_W]);
                    end
                end
                ST_RUN: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == last_idx) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (acc_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= M_DATA_W'(world);
                        m_user_reg  <= M_USER_W'(sat);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `IEM_ASSERT_IMPLIES(a_done_in_drain, acc_done, state_reg == ST_DRAIN,
        "accumulation finished outside drain")
    `IEM_ASSERT_IMPLIES(a_prism_slots, (state_reg == ST_RUN) && (kind_reg == KIND_PRISM),
        idx_reg <= LAST_PRISM, "prism read beyond its six slots")
    `IEM_ASSERT_NEXT(a_result_issued, (state_reg == ST_DONE) && (!m_tvalid || m_tready),
        m_tvalid && (state_reg == ST_IDLE), "result not moved to output register")

endmodule

`default_nettype wire
